/* design/cbp_pkg.sv */
`default_nettype none

package cbp_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Register widths
  localparam int DPAT_W     = 64;
  localparam int PLEN_W     = 6;
  localparam int TPAT_W     = 32;
  localparam int TLEN_W     = 5;
  localparam int DLEN_W     = 24;

  // Frame state widths
  localparam int POS_W      = 5;
  localparam int TAIL_IDX_W = 5;

  // UMTS tail layout: four rows per tail column, lower encoder starts at row 2
  localparam int ROWS_UMTS       = 4;
  localparam int LOWER_ROW_FIRST = 2;
  localparam int LOWER_DEPTH     = 8;
  localparam int LOWER_ADDR_W    = 3;
  localparam int FILL_W          = 4;

  // Results per input transaction
  localparam int MAX_RESULTS = 24;
  localparam int RES_W       = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_PATTERN    = 3'd0,
    REG_PATTERN_LENGTH  = 3'd1,
    REG_TAIL_PATTERN    = 3'd2,
    REG_TAIL_LENGTH     = 3'd3,
    REG_DATA_LENGTH     = 3'd4,
    REG_UMTS_TAIL_ORDER = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic start;   // take the input bit, update frame counters
    logic gen;     // produce one copy of cur_bit
    logic load;    // fetch next buffered lower tail bit
    logic finish;  // push the held result out as last of run
  } cmd_t;

  typedef struct packed {
    logic rep_zero;
    logic at_cap;
    logic flush_pending;
    logic flush_done;
    logic can_gen;
    logic hold_valid;
  } status_t;

endpackage

`default_nettype wire

/* design/cbp_ctrl.sv */
`default_nettype none

module cbp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cbp_pkg::status_t status,
  output cbp_pkg::cmd_t         cmd
);
  import cbp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EMIT   = 4'b0010,
    S_LOAD   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.rep_zero || status.at_cap) begin
          state_next = (status.flush_pending && !status.at_cap) ? S_LOAD : S_FINISH;
        end else if (status.can_gen) begin
          cmd.gen = 1'b1;
        end
      end
      S_LOAD: begin
        if (status.flush_done || status.at_cap) begin
          state_next = S_FINISH;
        end else begin
          cmd.load   = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_FINISH: begin
        if (!status.hold_valid) begin
          state_next = S_IDLE;
        end else if (status.can_gen) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // nothing may be left in the hold stage once a new input can be taken
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !status.hold_valid)
    else $error("hold stage occupied while idle");

endmodule

`default_nettype wire

/* design/cbp_datapath.sv */
`default_nettype none

module cbp_datapath #(
  parameter int MAX_PATTERN_ENTRIES = 32,
  parameter int MAX_TAIL_ENTRIES    = 16,
  parameter int COUNT_BITS          = 2,
  parameter int DATA_COUNT_BITS     = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic [cbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cbp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           code_bit,
  input  wire cbp_pkg::cmd_t                  cmd,
  output cbp_pkg::status_t                    status,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_bit,
  output logic                                last_of_run
);
  import cbp_pkg::*;

  localparam int CMP_W = (DATA_COUNT_BITS > DLEN_W) ? DATA_COUNT_BITS : DLEN_W;
  localparam logic [PLEN_W-1:0]     PLEN_MAX = PLEN_W'(MAX_PATTERN_ENTRIES);
  localparam logic [TAIL_IDX_W-1:0] TLEN_MAX = TAIL_IDX_W'(MAX_TAIL_ENTRIES);

  // configuration
  logic [DPAT_W-1:0] data_pattern;
  logic [PLEN_W-1:0] pattern_length;
  logic [TPAT_W-1:0] tail_pattern_word;
  logic [TLEN_W-1:0] tail_length;
  logic [DLEN_W-1:0] data_length;
  logic              umts_tail_order;

  // frame state
  logic [POS_W-1:0]           pattern_position;
  logic [DATA_COUNT_BITS-1:0] data_counter;
  logic [TAIL_IDX_W-1:0]      tail_index;
  logic [FILL_W-1:0]          lower_tail_fill;
  logic                       lower_tail_store [LOWER_DEPTH];

  // per-transaction work
  logic                  cur_bit;
  logic [COUNT_BITS-1:0] rep;
  logic                  flush_pending;
  logic [FILL_W-1:0]     flush_n;
  logic [FILL_W-1:0]     flush_k;
  logic [RES_W-1:0]      n_emitted;
  logic                  hold_valid;
  logic                  hold_bit;

  // decode of the current step
  logic [PLEN_W-1:0]     plen_eff;
  logic [TAIL_IDX_W-1:0] tlen_eff;
  logic [POS_W-1:0]      pos_eff;
  logic [PLEN_W-1:0]     pos_inc;
  logic [POS_W-1:0]      pos_wrap;
  logic                  in_data;
  logic [DATA_COUNT_BITS-1:0] cnt_inc;
  logic                  data_done;
  logic                  tail_over;
  logic                  is_lower;
  logic                  store_ok;
  logic                  store_we;
  logic [FILL_W-1:0]     fill_inc;
  logic [TAIL_IDX_W-1:0] tidx_inc;
  logic                  tail_last;
  logic [5:0]            dbase;
  logic [4:0]            tbase;
  logic [3:0]            fpos;
  logic [4:0]            fbase;
  logic [COUNT_BITS-1:0] data_cnt;
  logic [COUNT_BITS-1:0] tail_cnt;
  logic [COUNT_BITS-1:0] flush_cnt;
  logic                  out_free;

  always_comb begin
    if (pattern_length == '0) begin
      plen_eff = PLEN_W'(1);
    end else if (pattern_length > PLEN_MAX) begin
      plen_eff = PLEN_MAX;
    end else begin
      plen_eff = pattern_length;
    end
    tlen_eff  = (tail_length > TLEN_MAX) ? TLEN_MAX : tail_length;
    pos_eff   = ({1'b0, pattern_position} >= plen_eff) ? '0 : pattern_position;
    pos_inc   = {1'b0, pos_eff} + PLEN_W'(1);
    pos_wrap  = (pos_inc >= plen_eff) ? '0 : pos_inc[POS_W-1:0];
    in_data   = CMP_W'(data_counter) < CMP_W'(data_length);
    cnt_inc   = data_counter + DATA_COUNT_BITS'(1);
    data_done = (CMP_W'(cnt_inc) >= CMP_W'(data_length)) && (tlen_eff == '0);
    tail_over = tail_index >= tlen_eff;
    is_lower  = umts_tail_order && tail_index[1];
    store_ok  = lower_tail_fill < FILL_W'(LOWER_DEPTH);
    store_we  = cmd.start && !in_data && !tail_over && is_lower && store_ok;
    fill_inc  = lower_tail_fill + FILL_W'(is_lower && store_ok);
    tidx_inc  = tail_index + TAIL_IDX_W'(1);
    tail_last = tidx_inc >= tlen_eff;
    // lower bit k sits at row 2 + (k & 1) of tail column k / 2
    fpos      = 4'((int'(flush_k[2:1]) * ROWS_UMTS) + LOWER_ROW_FIRST + int'(flush_k[0]));
    dbase     = 6'(COUNT_BITS * int'(pos_eff));
    tbase     = 5'(COUNT_BITS * int'(tail_index[3:0]));
    fbase     = 5'(COUNT_BITS * int'(fpos));
    data_cnt  = data_pattern[dbase +: COUNT_BITS];
    tail_cnt  = tail_pattern_word[tbase +: COUNT_BITS];
    flush_cnt = tail_pattern_word[fbase +: COUNT_BITS];
    out_free  = !out_valid || out_ready;
  end

  assign status.rep_zero      = (rep == '0);
  assign status.at_cap        = (n_emitted == RES_W'(MAX_RESULTS));
  assign status.flush_pending = flush_pending;
  assign status.flush_done    = (flush_k >= flush_n);
  assign status.can_gen       = !hold_valid || out_free;
  assign status.hold_valid    = hold_valid;

  // control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      data_pattern      <= '0;
      pattern_length    <= PLEN_W'(1);
      tail_pattern_word <= '0;
      tail_length       <= '0;
      data_length       <= '0;
      umts_tail_order   <= 1'b0;
      pattern_position  <= '0;
      data_counter      <= '0;
      tail_index        <= '0;
      lower_tail_fill   <= '0;
      flush_pending     <= 1'b0;
      flush_n           <= '0;
      flush_k           <= '0;
      n_emitted         <= '0;
      hold_valid        <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_DATA_PATTERN:    data_pattern      <= cfg_data;
          REG_PATTERN_LENGTH:  pattern_length    <= cfg_data[PLEN_W-1:0];
          REG_TAIL_PATTERN:    tail_pattern_word <= cfg_data[TPAT_W-1:0];
          REG_TAIL_LENGTH:     tail_length       <= cfg_data[TLEN_W-1:0];
          REG_DATA_LENGTH:     data_length       <= cfg_data[DLEN_W-1:0];
          REG_UMTS_TAIL_ORDER: umts_tail_order   <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.start) begin
        n_emitted        <= '0;
        flush_k          <= '0;
        flush_pending    <= 1'b0;
        pattern_position <= pos_eff;
        if (in_data) begin
          pattern_position <= pos_wrap;
          data_counter     <= cnt_inc;
          if (data_done) begin
            pattern_position <= '0;
            data_counter     <= '0;
            tail_index       <= '0;
            lower_tail_fill  <= '0;
          end
        end else if (tail_over) begin
          pattern_position <= '0;
          data_counter     <= '0;
          tail_index       <= '0;
          lower_tail_fill  <= '0;
        end else begin
          lower_tail_fill <= fill_inc;
          tail_index      <= tidx_inc;
          if (tail_last) begin
            flush_pending    <= 1'b1;
            flush_n          <= fill_inc;
            pattern_position <= '0;
            data_counter     <= '0;
            tail_index       <= '0;
            lower_tail_fill  <= '0;
          end
        end
      end

      if (cmd.gen) begin
        n_emitted  <= n_emitted + RES_W'(1);
        hold_valid <= 1'b1;
        if (hold_valid) begin
          out_valid <= 1'b1;
        end
      end

      if (cmd.load) begin
        flush_k <= flush_k + FILL_W'(1);
      end

      if (cmd.finish) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_bit <= code_bit;
      if (in_data) begin
        rep <= data_cnt;
      end else if (tail_over || is_lower) begin
        rep <= '0;
      end else begin
        rep <= tail_cnt;
      end
    end
    if (cmd.gen) begin
      rep      <= rep - COUNT_BITS'(1);
      hold_bit <= cur_bit;
      if (hold_valid) begin
        out_bit     <= hold_bit;
        last_of_run <= 1'b0;
      end
    end
    if (cmd.load) begin
      cur_bit <= lower_tail_store[flush_k[LOWER_ADDR_W-1:0]];
      rep     <= flush_cnt;
    end
    if (cmd.finish) begin
      out_bit     <= hold_bit;
      last_of_run <= 1'b1;
    end
  end

  // lower encoder tail buffer
  always_ff @(posedge clk) begin
    if (store_we) begin
      lower_tail_store[lower_tail_fill[LOWER_ADDR_W-1:0]] <= code_bit;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    n_emitted <= RES_W'(MAX_RESULTS))
    else $error("result count past limit");

  assert property (@(posedge clk) disable iff (rst)
    lower_tail_fill <= FILL_W'(LOWER_DEPTH))
    else $error("lower tail buffer overfilled");

  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (out_valid && last_of_run && !hold_valid))
    else $error("run end not presented");

endmodule

`default_nettype wire

/* design/code_bit_puncturer_core.sv */
// code_bit_puncturer_core
//
// Punctures and repeats the code bits of one encoder frame. Code bits enter on
// the input channel (in_valid/in_ready, code_bit), one bit per transaction.
// Results leave on the output channel (out_valid/out_ready, out_bit,
// last_of_run); last_of_run marks the final result caused by one input bit.
// An input bit that is deleted produces no output transaction at all.
// Registers are written through cfg_valid/cfg_ready, cfg_index, cfg_data;
// cfg_ready is always high and unknown indexes are dropped.
//
// Timing: one input bit is handled at a time. The last tail bit of a frame
// also flushes each buffered lower bit, with that bit's own copy count.
// Each copy enters a hold stage and moves to the output register when the
// next copy is made or the run ends; the last result lands as in_ready
// returns. The rate is set by the controller's one-copy-per-cycle emit loop,
// which waits while the output stalls.
//
// Reset (rst, synchronous) restores register defaults and clears all frame
// counters. When the receiver stalls, one result waits in the output
// register and one in a hold stage; further copies wait until it drains.

`default_nettype none

module code_bit_puncturer_core #(
  parameter int MAX_PATTERN_ENTRIES = 32,
  parameter int MAX_TAIL_ENTRIES    = 16,
  parameter int COUNT_BITS          = 2,
  parameter int DATA_COUNT_BITS     = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // code bit input
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           code_bit,
  // result output
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_bit,
  output logic                                last_of_run,
  // register writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cbp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cbp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // register writes always taken; user must land them while idle, unchecked
  assign cfg_ready = 1'b1;

  // sequencing: accept, emit copies, optional lower tail flush, close run
  cbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // registers, frame counters, lower tail buffer and output staging
  cbp_datapath #(
    .MAX_PATTERN_ENTRIES (MAX_PATTERN_ENTRIES),
    .MAX_TAIL_ENTRIES    (MAX_TAIL_ENTRIES),
    .COUNT_BITS          (COUNT_BITS),
    .DATA_COUNT_BITS     (DATA_COUNT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .code_bit    (code_bit),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_bit     (out_bit),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
